[sv/ckp_pkg.sv]
// Shared types, constants and codes for the chunk key parser.
package ckp_pkg;

    // Sizes of the key format.
    localparam int MAX_DIMS  = 4;
    localparam int ID_W      = 32;
    localparam int DIM_IDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int DIM_CNT_W = $clog2(MAX_DIMS + 1);
    localparam int CHAR_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [ID_W-1:0] ID_MAX = '1;

    // Reset values of the configuration registers.
    localparam logic [CHAR_W-1:0]    SEP_RESET    = 8'd46;
    localparam logic [DIM_CNT_W-1:0] DIMS_RESET   = DIM_CNT_W'(1);
    localparam logic [ID_W-1:0]      CHUNKS_RESET = ID_W'(1);

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_CHAR = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BOUNDS   = 3'd3,
        ST_MISMATCH = 3'd4
    } status_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEPARATOR = 3'd0,
        CFG_DIMS      = 3'd1,
        CFG_CHUNKS0   = 3'd2,
        CFG_CHUNKS1   = 3'd3,
        CFG_CHUNKS2   = 3'd4,
        CFG_CHUNKS3   = 3'd5
    } cfg_idx_t;

    // Current configuration as seen by the parser.
    typedef struct packed {
        logic [CHAR_W-1:0]                  separator;
        logic [DIM_CNT_W-1:0]               dims_in_use;
        logic [MAX_DIMS-1:0][ID_W-1:0]      chunks;
    } cfg_t;

    // One key character handed from the input register to the parser.
    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] ch;
        logic              last;
    } step_t;

    // One parse result.
    typedef struct packed {
        status_t                       status;
        logic [DIM_CNT_W-1:0]          dims_found;
        logic [MAX_DIMS-1:0][ID_W-1:0] ids;
    } res_t;

endpackage

[sv/ckp_cfg_regs.sv]
// Configuration register file for the chunk key parser.
module ckp_cfg_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [ckp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ckp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output ckp_pkg::cfg_t                    cfg
);
    import ckp_pkg::*;

    cfg_t cfg_reg;

    // Write the addressed register; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.separator   <= SEP_RESET;
            cfg_reg.dims_in_use <= DIMS_RESET;
            for (int k = 0; k < MAX_DIMS; k++)
            begin
                cfg_reg.chunks[k] <= CHUNKS_RESET;
            end
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SEPARATOR: cfg_reg.separator   <= cfg_wdata[CHAR_W-1:0];
                CFG_DIMS:      cfg_reg.dims_in_use <= cfg_wdata[DIM_CNT_W-1:0];
                CFG_CHUNKS0:   cfg_reg.chunks[0]   <= cfg_wdata[ID_W-1:0];
                CFG_CHUNKS1:   cfg_reg.chunks[1]   <= cfg_wdata[ID_W-1:0];
                CFG_CHUNKS2:   cfg_reg.chunks[2]   <= cfg_wdata[ID_W-1:0];
                CFG_CHUNKS3:   cfg_reg.chunks[3]   <= cfg_wdata[ID_W-1:0];
                default:       ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[sv/ckp_digit_acc.sv]
// Saturating decimal accumulate: times ten plus one digit.
module ckp_digit_acc
(
    input  logic [ckp_pkg::ID_W-1:0]   acc,
    input  logic [ckp_pkg::CHAR_W-1:0] ch,
    output logic                       is_digit,
    output logic [ckp_pkg::ID_W-1:0]   acc_next
);
    import ckp_pkg::*;

    logic [ID_W+3:0] wide_acc;
    logic [ID_W+3:0] sum;
    logic [3:0]      digit;

    // An ASCII digit carries its value in the low nibble.
    assign is_digit = (ch >= 8'h30) && (ch <= 8'h39);
    assign digit    = ch[3:0];

    // Ten times the accumulator as two shifts, then the digit; any carry
    // above the id width means the value no longer fits and saturates.
    always_comb
    begin
        wide_acc = {4'b0000, acc};
        sum      = (wide_acc << 3) + (wide_acc << 1) + {{ID_W{1'b0}}, digit};
        if (sum[ID_W+3:ID_W] != 4'b0000)
        begin
            acc_next = ID_MAX;
        end
        else
        begin
            acc_next = sum[ID_W-1:0];
        end
    end

endmodule

[sv/ckp_parser.sv]
// Parse state, field close and bounds check, and the result register.
module ckp_parser
(
    input  logic           clk,
    input  logic           rst_n,
    input  ckp_pkg::cfg_t  cfg,
    input  ckp_pkg::step_t step,
    output logic           step_ready,
    output logic           res_valid,
    input  logic           res_stall,
    output ckp_pkg::res_t  res
);
    import ckp_pkg::*;

    logic [ID_W-1:0]       acc_reg, acc_next;
    logic                  has_reg, has_next;
    logic [DIM_CNT_W-1:0]  cnt_reg, cnt_next;
    status_t               err_reg, err_next;
    logic [ID_W-1:0]       ids_reg [MAX_DIMS];
    logic                  res_valid_reg;
    res_t                  res_reg;

    logic                  step_go;
    logic                  is_digit;
    logic [ID_W-1:0]       acc_dig;
    logic                  do_close;
    logic [ID_W-1:0]       close_id;
    logic                  id_we;
    logic [DIM_CNT_W-1:0]  limit;
    logic [ID_W-1:0]       chunk_sel;
    status_t               res_status;
    logic [MAX_DIMS-1:0][ID_W-1:0] ids_out;

    ckp_digit_acc u_digit_acc
    (
        .acc      (acc_reg),
        .ch       (step.ch),
        .is_digit (is_digit),
        .acc_next (acc_dig)
    );

    // A word that ends a key needs a free result register.
    assign step_ready = !step.last || !res_valid_reg || !res_stall;
    assign step_go    = step.valid && step_ready;

    // Ids beyond the configured count are refused, as are ids beyond the store.
    assign limit     = (cfg.dims_in_use > DIM_CNT_W'(MAX_DIMS)) ? DIM_CNT_W'(MAX_DIMS)
                                                               : cfg.dims_in_use;
    assign chunk_sel = cfg.chunks[cnt_reg[DIM_IDX_W-1:0]];

    // Next parse state for the current character.
    always_comb
    begin
        err_next = err_reg;
        acc_next = acc_reg;
        has_next = has_reg;
        cnt_next = cnt_reg;
        do_close = 1'b0;
        close_id = acc_reg;
        id_we    = 1'b0;

        if (err_reg == ST_OK)
        begin
            if (is_digit)
            begin
                acc_next = acc_dig;
                has_next = 1'b1;
                if (step.last)
                begin
                    do_close = 1'b1;
                    close_id = acc_dig;
                end
            end
            else if (step.ch == cfg.separator)
            begin
                if (!has_reg)
                begin
                    err_next = ST_EMPTY;
                end
                else
                begin
                    do_close = 1'b1;
                end
            end
            else
            begin
                err_next = ST_BAD_CHAR;
            end
        end

        // Closing a field checks the count, then the bound, then stores.
        if (do_close)
        begin
            if (cnt_reg >= limit)
            begin
                err_next = ST_MISMATCH;
            end
            else if ((close_id == ID_MAX) || (close_id >= chunk_sel))
            begin
                err_next = ST_BOUNDS;
            end
            else
            begin
                id_we    = 1'b1;
                cnt_next = cnt_reg + DIM_CNT_W'(1);
                acc_next = '0;
                has_next = 1'b0;
            end
        end

        // A clean key must hold exactly the configured number of ids.
        res_status = err_next;
        if ((err_next == ST_OK) && (cnt_next != cfg.dims_in_use))
        begin
            res_status = ST_MISMATCH;
        end
    end

    // Result ids: stored ones plus the one closed now, zero past the count.
    always_comb
    begin
        for (int k = 0; k < MAX_DIMS; k++)
        begin
            if (DIM_CNT_W'(k) >= cnt_next)
            begin
                ids_out[k] = '0;
            end
            else if (id_we && (cnt_reg[DIM_IDX_W-1:0] == DIM_IDX_W'(k)))
            begin
                ids_out[k] = close_id;
            end
            else
            begin
                ids_out[k] = ids_reg[k];
            end
        end
    end

    // Parse state; the last word of a key returns it to the start.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            has_reg <= 1'b0;
            cnt_reg <= '0;
            err_reg <= ST_OK;
        end
        else if (step_go)
        begin
            if (step.last)
            begin
                acc_reg <= '0;
                has_reg <= 1'b0;
                cnt_reg <= '0;
                err_reg <= ST_OK;
            end
            else
            begin
                acc_reg <= acc_next;
                has_reg <= has_next;
                cnt_reg <= cnt_next;
                err_reg <= err_next;
            end
        end
    end

    // Id store; entries at or past the count are masked on read.
    always_ff @(posedge clk)
    begin
        if (step_go && id_we)
        begin
            ids_reg[cnt_reg[DIM_IDX_W-1:0]] <= close_id;
        end
    end

    // Result register with its valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (step_go && step.last)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_go && step.last)
        begin
            res_reg.status     <= res_status;
            res_reg.dims_found <= cnt_next;
            res_reg.ids        <= ids_out;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // The id count never passes the size of the store.
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DIM_CNT_W'(MAX_DIMS))
        else $error("parsed id count beyond store size");

    // A key end is never taken while a held result waits.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_stall) |-> !(step_go && step.last))
        else $error("result overwritten while stalled");

    // After a key end the parse starts clean.
    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (step_go && step.last) |=> (cnt_reg == '0) && (err_reg == ST_OK) && !has_reg)
        else $error("parse state not cleared after key end");

    // A clean result always carries at least one id.
    a_ok_has_ids: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (res_reg.status == ST_OK)) |-> (res_reg.dims_found != '0))
        else $error("ok result with no ids");

endmodule

[sv/chunk_key_parser.sv]
// Chunk key parser top level: input register, configuration and parser.
//
//  channel   direction  handshake              payload
//  key in    input      in_valid / in_stall    key_char, key_end
//  result    output     out_valid / out_stall  status, dims_found, id_dim0..id_dim3
//  config    input      cfg_wr_en              cfg_index, cfg_wdata
//
// One key character is taken per cycle unless in_stall is high; the last
// character passes through the input register and then the result register
// before its result is offered. The character step (accumulate, close and
// bounds check) is combinational between the input register and the result
// register. Reset clears the parse state and loads the register defaults.
// A stalled result holds back only the last word of the next key.
module chunk_key_parser
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [ckp_pkg::CHAR_W-1:0]      key_char,
    input  logic                            key_end,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [2:0]                      status,
    output logic [ckp_pkg::DIM_CNT_W-1:0]   dims_found,
    output logic [ckp_pkg::ID_W-1:0]        id_dim0,
    output logic [ckp_pkg::ID_W-1:0]        id_dim1,
    output logic [ckp_pkg::ID_W-1:0]        id_dim2,
    output logic [ckp_pkg::ID_W-1:0]        id_dim3,
    input  logic                            cfg_wr_en,
    input  logic [ckp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ckp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import ckp_pkg::*;

    cfg_t              cfg;
    step_t             step;
    res_t              res;
    logic              step_ready;
    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_end_reg;
    logic              in_take;

    ckp_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Input register: refills whenever its word moves on to the parser.
    assign in_stall = in_valid_reg && !step_ready;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_char_reg <= key_char;
            in_end_reg  <= key_end;
        end
    end

    assign step.valid = in_valid_reg;
    assign step.ch    = in_char_reg;
    assign step.last  = in_end_reg;

    ckp_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .step       (step),
        .step_ready (step_ready),
        .res_valid  (out_valid),
        .res_stall  (out_stall),
        .res        (res)
    );

    // Result fields onto their own ports.
    assign status     = res.status;
    assign dims_found = res.dims_found;
    assign id_dim0    = res.ids[0];
    assign id_dim1    = res.ids[1];
    assign id_dim2    = res.ids[2];
    assign id_dim3    = res.ids[3];

endmodule

[test/testbench.sv]
// Self-checking testbench for the chunk key parser.
`timescale 1ns / 1ps

module testbench;
    import ckp_pkg::*;

    localparam int QUIET_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASES        = 8;
    localparam int PHASE_WORDS   = 225;
    localparam int SETTLE_CYCLES = 4;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    typedef logic [7:0] char_q_t[$];

    // Predicts parse results from accepted key words and holds them in order.
    class key_scoreboard;
        logic [7:0]  sep;
        logic [2:0]  dims;
        logic [31:0] chunks[MAX_DIMS];
        logic [31:0] acc;
        bit          has_digits;
        logic [2:0]  nparsed;
        status_t     err;
        logic [31:0] ids[MAX_DIMS];
        res_t        results_q[$];
        int          errors;

        function new();
            sep = SEP_RESET;
            dims = DIMS_RESET;
            foreach (chunks[k])
                chunks[k] = CHUNKS_RESET;
            errors = 0;
            clear_key();
        endfunction

        function void clear_key();
            acc = '0;
            has_digits = 1'b0;
            nparsed = '0;
            err = ST_OK;
            foreach (ids[k])
                ids[k] = '0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [31:0] value);
            case (idx)
                CFG_SEPARATOR: sep = value[7:0];
                CFG_DIMS:      dims = value[2:0];
                CFG_CHUNKS0:   chunks[0] = value;
                CFG_CHUNKS1:   chunks[1] = value;
                CFG_CHUNKS2:   chunks[2] = value;
                CFG_CHUNKS3:   chunks[3] = value;
                default: ;
            endcase
        endfunction

        // Close the current field: count check first, then the bound check.
        function void close_id();
            int limit;
            limit = (dims < MAX_DIMS) ? int'(dims) : MAX_DIMS;
            if (int'(nparsed) >= limit)
                err = ST_MISMATCH;
            else if (acc == ID_MAX || acc >= chunks[nparsed[1:0]])
                err = ST_BOUNDS;
            else
            begin
                ids[nparsed[1:0]] = acc;
                nparsed = nparsed + 3'd1;
                acc = '0;
                has_digits = 1'b0;
            end
        endfunction

        function void note_char(logic [7:0] ch, logic is_end);
            logic [63:0] digit;
            res_t        want;
            if (err == ST_OK)
            begin
                if (ch >= CH_ZERO && ch <= CH_NINE)
                begin
                    digit = 64'(ch - CH_ZERO);
                    // The id saturates instead of wrapping.
                    if (64'(acc) > (64'(ID_MAX) - digit) / 64'd10)
                        acc = ID_MAX;
                    else
                        acc = 32'(64'(acc) * 64'd10 + digit);
                    has_digits = 1'b1;
                    if (is_end)
                        close_id();
                end
                else if (ch == sep)
                begin
                    if (!has_digits)
                        err = ST_EMPTY;
                    else
                        close_id();
                end
                else
                    err = ST_BAD_CHAR;
            end
            if (is_end)
            begin
                if (err == ST_OK && nparsed != dims)
                    err = ST_MISMATCH;
                want.status = err;
                want.dims_found = nparsed;
                for (int k = 0; k < MAX_DIMS; k++)
                    want.ids[k] = (k < int'(nparsed)) ? ids[k] : '0;
                results_q.insert(results_q.size(), want);
                clear_key();
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (results_q.size() == 0)
            begin
                $display("%0t: result with none expected: status %0d dims %0d",
                         $time, got.status, got.dims_found);
                errors++;
                return;
            end
            want = results_q.pop_front();
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d",
                         $time, want.status, got.status);
                errors++;
            end
            if (got.dims_found !== want.dims_found)
            begin
                $display("%0t: dims_found expected %0d actual %0d",
                         $time, want.dims_found, got.dims_found);
                errors++;
            end
            for (int k = 0; k < MAX_DIMS; k++)
            begin
                if (got.ids[k] !== want.ids[k])
                begin
                    $display("%0t: id_dim%0d expected %0d actual %0d",
                             $time, k, want.ids[k], got.ids[k]);
                    errors++;
                end
            end
        endfunction

        function int outstanding();
            return results_q.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [CHAR_W-1:0]     key_char = '0;
    logic                  key_end = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [2:0]            status;
    logic [DIM_CNT_W-1:0]  dims_found;
    logic [ID_W-1:0]       id_dim0;
    logic [ID_W-1:0]       id_dim1;
    logic [ID_W-1:0]       id_dim2;
    logic [ID_W-1:0]       id_dim3;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    key_scoreboard sb = new();

    // Generator's view of the configuration.
    logic [7:0]  cur_sep = SEP_RESET;
    logic [2:0]  cur_dims = DIMS_RESET;
    logic [31:0] cur_chunks[MAX_DIMS] = '{default: CHUNKS_RESET};

    char_q_t key_buf;
    int      words_sent = 0;
    bit      sender_calm = 1'b0;
    int      hold_requests = 0;
    int      holds_served = 0;
    int      quiet_cycles = 0;

    chunk_key_parser dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .key_char   (key_char),
        .key_end    (key_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .dims_found (dims_found),
        .id_dim0    (id_dim0),
        .id_dim1    (id_dim1),
        .id_dim2    (id_dim2),
        .id_dim3    (id_dim3),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Receiver stall pattern, with one long hold-off whenever one is requested.
    initial
    begin
        int stall_run;
        int free_run;
        stall_run = 0;
        free_run = 0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served++;
                stall_run = HOLD_CYCLES;
            end
            if (stall_run > 0)
            begin
                out_stall <= 1'b1;
                stall_run--;
            end
            else if (free_run > 0)
            begin
                out_stall <= 1'b0;
                free_run--;
            end
            else
            begin
                out_stall <= 1'b0;
                free_run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                      : $urandom_range(0, 6);
                stall_run = pick_gap();
            end
        end
    end

    // Check every result word taken from the block.
    always @(posedge clk)
    begin
        res_t got;
        if (out_valid && !out_stall)
        begin
            got.status = status_t'(status);
            got.dims_found = dims_found;
            got.ids[0] = id_dim0;
            got.ids[1] = id_dim1;
            got.ids[2] = id_dim2;
            got.ids[3] = id_dim3;
            sb.check_result(got);
        end
    end

    // End the run when no word moves on either side for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_word(logic [7:0] ch, logic is_end);
        int gap;
        gap = sender_calm ? 0 : pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        key_char <= ch;
        key_end <= is_end;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_char(ch, is_end);
        words_sent++;
    endtask

    task automatic send_key();
        foreach (key_buf[i])
            send_word(key_buf[i], i == key_buf.size() - 1);
    endtask

    // Add one byte at the end of the key being built.
    function automatic void append_char(logic [7:0] c);
        key_buf.insert(key_buf.size(), c);
    endfunction

    function automatic void load_text(string s);
        key_buf.delete();
        for (int i = 0; i < s.len(); i++)
            append_char(8'(s[i]));
    endfunction

    // Stop offering words and let every result come back before a register write.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(cfg_idx_t idx, logic [31:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        sb.write_reg(idx, value);
        case (idx)
            CFG_SEPARATOR: cur_sep = value[7:0];
            CFG_DIMS:      cur_dims = value[2:0];
            CFG_CHUNKS0:   cur_chunks[0] = value;
            CFG_CHUNKS1:   cur_chunks[1] = value;
            CFG_CHUNKS2:   cur_chunks[2] = value;
            CFG_CHUNKS3:   cur_chunks[3] = value;
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [31:0] pick_chunks();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 32'd0;
        else if (r < 15)
            return 32'd1;
        else if (r < 30)
            return 32'hFFFF_FFFF;
        else if (r < 60)
            return $urandom_range(2, 12);
        else if (r < 85)
            return $urandom_range(13, 100000);
        return $urandom;
    endfunction

    // Each phase has its own setting; the first few pin the extremes.
    task automatic configure_phase(int ph);
        logic [7:0]  sep;
        logic [31:0] dims;
        logic [31:0] chunks[MAX_DIMS];
        foreach (chunks[k])
            chunks[k] = pick_chunks();
        case (ph)
            0:
            begin
                sep = 8'h2E;
                dims = 4;
                foreach (chunks[k])
                    chunks[k] = 32'hFFFF_FFFF;
            end
            1:
            begin
                sep = 8'h00;
                dims = 1;
                foreach (chunks[k])
                    chunks[k] = 32'd1;
            end
            2:
            begin
                sep = 8'hFF;
                dims = 3;
            end
            3:
            begin
                sep = 8'h35;
                dims = 1;
            end
            4:
            begin
                sep = 8'h2F;
                dims = 0;
            end
            5:
            begin
                sep = 8'h3A;
                dims = $urandom_range(5, 7);
            end
            default:
            begin
                sep = ($urandom_range(0, 1) == 0) ? 8'h2E : 8'($urandom_range(0, 255));
                dims = $urandom_range(1, 4);
            end
        endcase
        set_reg(CFG_SEPARATOR, 32'(sep));
        set_reg(CFG_DIMS, dims);
        set_reg(CFG_CHUNKS0, chunks[0]);
        set_reg(CFG_CHUNKS1, chunks[1]);
        set_reg(CFG_CHUNKS2, chunks[2]);
        set_reg(CFG_CHUNKS3, chunks[3]);
        end_writes();
    endtask

    function automatic void push_decimal(longint unsigned value);
        char_q_t         digs;
        longint unsigned rest;
        rest = value;
        do
        begin
            digs.push_front(8'(64'(CH_ZERO) + rest % 10));
            rest = rest / 10;
        end
        while (rest != 0);
        foreach (digs[i])
            append_char(digs[i]);
    endfunction

    function automatic logic [7:0] pick_bad_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while ((c >= CH_ZERO && c <= CH_NINE) || c == cur_sep);
        return c;
    endfunction

    // Mostly well-formed keys with random ids; some broken, some pure noise.
    function automatic void build_key();
        int          nfields;
        int          r;
        int          pos;
        logic [31:0] bound;
        key_buf.delete();
        if ($urandom_range(0, 99) < 4)
        begin
            repeat ($urandom_range(1, 6))
                append_char(8'($urandom_range(0, 255)));
            return;
        end
        if (cur_dims >= 1 && cur_dims <= MAX_DIMS && $urandom_range(0, 9) != 0)
            nfields = int'(cur_dims);
        else
            nfields = $urandom_range(1, 5);
        for (int f = 0; f < nfields; f++)
        begin
            if (f > 0)
                append_char(cur_sep);
            bound = cur_chunks[f % MAX_DIMS];
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 19) == 0)
                append_char(CH_ZERO);
            if (r < 3)
            begin
                // Far more digits than an id can hold.
                append_char(8'(64'(CH_ZERO) + $urandom_range(1, 9)));
                repeat ($urandom_range(10, 20))
                    append_char(8'(64'(CH_ZERO) + $urandom_range(0, 9)));
            end
            else if (r < 7)
                push_decimal(64'(bound) + $urandom_range(0, 3));
            else if (bound == 0)
                push_decimal($urandom_range(0, 9));
            else if (bound > 100 && $urandom_range(0, 1) == 0)
                push_decimal($urandom_range(0, 99));
            else
                push_decimal($urandom_range(0, bound - 1));
        end
        if ($urandom_range(0, 9) == 0)
            append_char(cur_sep);
        // Break some keys: stray byte, extra separator or overwritten byte.
        if ($urandom_range(0, 99) < 15)
        begin
            pos = $urandom_range(0, key_buf.size() - 1);
            case ($urandom_range(0, 2))
                0: key_buf.insert(pos, pick_bad_char());
                1: key_buf.insert(pos, cur_sep);
                default: key_buf[pos] = 8'($urandom_range(0, 255));
            endcase
        end
    endfunction

    initial
    begin
        int phase_start;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed keys under the reset setting: separator '.', one id below 1.
        sender_calm = 1'b1;
        load_text("0");   send_key();
        load_text("1");   send_key();
        load_text(".");   send_key();
        load_text("0.");  send_key();
        key_buf = '{8'hFF}; send_key();
        load_text("0.0"); send_key();
        key_buf = '{8'h00, 8'h35}; send_key();
        wait_idle();

        // Two ids, the first unbounded and the second with no chunks at all.
        set_reg(CFG_SEPARATOR, 32'h2F);
        set_reg(CFG_DIMS, 32'd2);
        set_reg(CFG_CHUNKS0, 32'hFFFF_FFFF);
        set_reg(CFG_CHUNKS1, 32'd0);
        end_writes();
        load_text("7");   send_key();
        load_text("7/0"); send_key();
        load_text("00/"); send_key();
        wait_idle();

        // Random phases, each under its own setting.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            configure_phase(ph);
            sender_calm = (ph % 3 == 0);
            if (ph == 2)
                hold_requests++;
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS)
            begin
                build_key();
                send_key();
            end
            wait_idle();
        end

        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[chunk_key_parser.f]
sv/ckp_pkg.sv
sv/ckp_cfg_regs.sv
sv/ckp_digit_acc.sv
sv/ckp_parser.sv
sv/chunk_key_parser.sv
test/testbench.sv
